// File: src/dom_pkg.sv
// Shared types, widths and status codes for the deadline ordered message queue.
`default_nettype none
package dom_pkg;
	localparam int DEFAULT_DEPTH = 16;
	localparam int TIME_W        = 64;
	localparam int CODE_W        = 32;
	localparam int HANDLE_W      = 32;
	localparam int STATUS_W      = 3;
	localparam int COUNT_OUT_W   = 5;
	localparam int S_DATA_W      = 192;
	localparam int M_DATA_W      = 136;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_DUE   = 3'd4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POLL   = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]   due;
		logic [CODE_W-1:0]   code;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_cmd_t;
endpackage
`default_nettype wire

// File: src/dom_cell.sv
// One slot of the sorted queue: holds an entry, shifts up on insert, down on pop.
`default_nettype none
module dom_cell (
	input  wire logic             clk,
	input  wire dom_pkg::cell_cmd_t cmd,
	input  wire logic             occupied,
	input  wire logic             take_prev,
	input  wire dom_pkg::entry_t  new_entry,
	input  wire dom_pkg::entry_t  prev_entry,
	input  wire dom_pkg::entry_t  next_entry,
	output logic                  take,
	output dom_pkg::entry_t       entry
);
	import dom_pkg::*;

	entry_t entry_q;

	// new item lands at or before this slot when slot is empty or later
	assign take  = !occupied || (new_entry.due < entry_q.due);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.insert && take && !take_prev) begin
			entry_q <= new_entry;
		end else if (cmd.insert && take) begin
			entry_q <= prev_entry;
		end else if (cmd.pop) begin
			entry_q <= next_entry;
		end
	end
endmodule
`default_nettype wire

// File: src/deadline_ordered_message_queue.sv
// Top level: sorted message queue built as a row of slot cells with a registered result.
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  s_      | in  | due_time, msg_code, msg_ref, now_time               | operation
//  m_      | out | out_code, out_ref, next_due, entry_count,           | status
//          |     | head_changed, zero pad                              |
//
// One transfer in per cycle; its result appears in the output register on the next cycle.
// Every cell compares its due time with the incoming one in parallel, and all cells shift together.
// Reset clears the entry count and the output valid; slot contents need no reset.
// The input stalls only while the output register holds a result not yet taken.
`default_nettype none
module deadline_ordered_message_queue #(
	parameter int QUEUE_DEPTH = dom_pkg::DEFAULT_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// due_time[63:0], msg_code[95:64], msg_ref[127:96], now_time[191:128]
	input  wire logic [dom_pkg::S_DATA_W-1:0] s_tdata,
	// operation[0]
	input  wire logic                         s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// out_code[31:0], out_ref[63:32], next_due[127:64], entry_count[132:128],
	// head_changed[133], zero[135:134]
	output logic [dom_pkg::M_DATA_W-1:0]      m_tdata,
	// status[2:0]
	output logic [dom_pkg::STATUS_W-1:0]      m_tuser
);
	import dom_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             is_poll;
	logic             full;
	logic             empty;
	logic             head_due;
	logic             do_insert;
	logic             do_pop;
	logic [TIME_W-1:0] now_time;
	entry_t           new_entry;
	cell_cmd_t        cmd;
	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_take  [QUEUE_DEPTH];

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [CODE_W-1:0]      out_code_q;
	logic [HANDLE_W-1:0]    out_ref_q;
	logic [TIME_W-1:0]      next_due_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;
	logic                   head_changed_q;
	logic [CNT_W-1:0]       count_next;
	logic [STATUS_W-1:0]    status_next;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_poll  = (s_tuser == OP_POLL);

	assign new_entry.due    = s_tdata[63:0];
	assign new_entry.code   = s_tdata[95:64];
	assign new_entry.handle = s_tdata[127:96];
	assign now_time         = s_tdata[191:128];

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_due  = (now_time >= cell_entry[0].due);
	assign do_insert = accept && !is_poll && !full;
	assign do_pop    = accept && is_poll && !empty && head_due;

	assign cmd.insert = do_insert;
	assign cmd.pop    = do_pop;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic   occ;
			logic   tprev;
			entry_t pentry;
			entry_t nentry;
			assign occ = (CNT_W'(gi) < count_q);
			if (gi == 0) begin : g_first
				assign tprev  = 1'b0;
				assign pentry = new_entry;
			end else begin : g_mid
				assign tprev  = cell_take[gi-1];
				assign pentry = cell_entry[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign nentry = cell_entry[gi];
			end else begin : g_inner
				assign nentry = cell_entry[gi+1];
			end
			dom_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occupied   (occ),
				.take_prev  (tprev),
				.new_entry  (new_entry),
				.prev_entry (pentry),
				.next_entry (nentry),
				.take       (cell_take[gi]),
				.entry      (cell_entry[gi])
			);
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		if (do_insert) begin
			count_next = count_q + 1'b1;
		end else if (do_pop) begin
			count_next = count_q - 1'b1;
		end
	end

	always_comb begin
		if (!is_poll) begin
			status_next = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			status_next = ST_EMPTY;
		end else if (head_due) begin
			status_next = ST_DELIVERED;
		end else begin
			status_next = ST_NOT_DUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_next;
			out_code_q     <= do_pop ? cell_entry[0].code : '0;
			out_ref_q      <= do_pop ? cell_entry[0].handle : '0;
			next_due_q     <= (status_next == ST_NOT_DUE) ? cell_entry[0].due : '0;
			head_changed_q <= do_insert && cell_take[0];
			entry_count_q  <= COUNT_OUT_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b00, head_changed_q, entry_count_q, next_due_q, out_ref_q, out_code_q};
endmodule
`default_nettype wire

// File: dv/tb_deadline_ordered_message_queue.sv
// Testbench for the deadline ordered message queue: directed and random traffic vs a predictor.
module tb_deadline_ordered_message_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import dom_pkg::*;

	localparam int DEPTH = DEFAULT_DEPTH;
	localparam logic [TIME_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [CODE_W-1:0]      code;
		logic [HANDLE_W-1:0]    handle;
		logic [TIME_W-1:0]      next_due;
		logic [COUNT_OUT_W-1:0] count;
		logic                   head;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	// model of the sorted queue, head at index 0
	logic [TIME_W-1:0]   q_due [DEPTH];
	logic [CODE_W-1:0]   q_code [DEPTH];
	logic [HANDLE_W-1:0] q_handle [DEPTH];
	int                  q_count = 0;
	outcome_t            pending [$];
	int                  errors = 0;

	int                  tx_idle_pct = 0;
	int                  rx_stall_pct = 0;
	int                  rx_hold = 0;
	logic [TIME_W-1:0]   time_base;

	deadline_ordered_message_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic outcome_t apply_to_queue(input logic op, input logic [TIME_W-1:0] due,
			input logic [CODE_W-1:0] code, input logic [HANDLE_W-1:0] handle,
			input logic [TIME_W-1:0] now);
		outcome_t r;
		int pos;
		int i;
		r = '0;
		if (op == OP_INSERT) begin
			if (q_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = q_count;
				while (pos > 0 && due < q_due[pos-1]) begin
					q_due[pos]    = q_due[pos-1];
					q_code[pos]   = q_code[pos-1];
					q_handle[pos] = q_handle[pos-1];
					pos--;
				end
				q_due[pos]    = due;
				q_code[pos]   = code;
				q_handle[pos] = handle;
				q_count++;
				r.head   = (pos == 0);
				r.status = ST_INSERTED;
			end
		end else if (q_count == 0) begin
			r.status = ST_EMPTY;
		end else if (now >= q_due[0]) begin
			r.code   = q_code[0];
			r.handle = q_handle[0];
			for (i = 1; i < q_count; i++) begin
				q_due[i-1]    = q_due[i];
				q_code[i-1]   = q_code[i];
				q_handle[i-1] = q_handle[i];
			end
			q_count--;
			r.status = ST_DELIVERED;
		end else begin
			r.next_due = q_due[0];
			r.status   = ST_NOT_DUE;
		end
		r.count = q_count[COUNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending.push_back(apply_to_queue(s_tuser, s_tdata[63:0], s_tdata[95:64],
					s_tdata[127:96], s_tdata[191:128]));
			if (m_tvalid && m_tready) begin
				got.status   = m_tuser;
				got.code     = m_tdata[31:0];
				got.handle   = m_tdata[63:32];
				got.next_due = m_tdata[127:64];
				got.count    = m_tdata[132:128];
				got.head     = m_tdata[133];
				if (pending.size() == 0) begin
					$display("%0t: unexpected result, expected none actual status %0d data %0h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = pending.pop_front();
					compare_field("status", want.status, got.status);
					compare_field("out_code", want.code, got.code);
					compare_field("out_ref", want.handle, got.handle);
					compare_field("next_due", want.next_due, got.next_due);
					compare_field("entry_count", want.count, got.count);
					compare_field("head_changed", want.head, got.head);
					compare_field("pad", {TIME_W{1'b0}}, {62'd0, m_tdata[135:134]});
				end
			end
		end
	end

	// long hold-offs take priority over random stalls
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready = 1'b0;
			rx_hold--;
		end else begin
			m_tready = ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// entered and left at a falling edge; valid stays up for back-to-back transfers
	task automatic send_item(input logic op, input logic [TIME_W-1:0] due,
			input logic [CODE_W-1:0] code, input logic [HANDLE_W-1:0] handle,
			input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {now, handle, code, due};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic test_directed_order();
		send_item(OP_POLL, 64'd7, 32'd1, 32'd2, 64'd0);
		send_item(OP_INSERT, T_MAX, 32'h8000_0000, 32'hFFFF_FFFF, 64'd0);
		send_item(OP_INSERT, 64'd0, 32'h7FFF_FFFF, 32'd0, T_MAX);
		send_item(OP_INSERT, 64'd5, 32'h0000_00AA, 32'h1111_1111, 64'd0);
		// equal due time keeps arrival order
		send_item(OP_INSERT, 64'd5, 32'h0000_00BB, 32'h2222_2222, 64'd0);
		send_item(OP_POLL, 64'd0, 32'd0, 32'd0, 64'd0);
		send_item(OP_POLL, 64'd0, 32'd0, 32'd0, 64'd4);
		send_item(OP_POLL, 64'd0, 32'd0, 32'd0, 64'd5);
		send_item(OP_POLL, 64'd0, 32'd0, 32'd0, T_MAX - 1);
		send_item(OP_POLL, 64'd0, 32'd0, 32'd0, T_MAX - 1);
		send_item(OP_POLL, 64'd0, 32'd0, 32'd0, T_MAX);
	endtask

	task automatic test_full_queue();
		int i;
		for (i = 0; i < DEPTH; i++)
			send_item(OP_INSERT, 64'd100 * ((i * 7) % 5), i, ~i, 64'd0);
		// rejected because the queue is full, even with the earliest possible due time
		send_item(OP_INSERT, 64'd0, 32'hDEAD_0001, 32'hBEEF_0001, 64'd0);
	endtask

	task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
		int n;
		int fill_bias;
		logic op;
		logic [TIME_W-1:0] due;
		logic [TIME_W-1:0] now;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		time_base    = {$urandom, $urandom};
		fill_bias    = 50;
		for (n = 0; n < count; n++) begin
			if (n % 40 == 0)
				fill_bias = $urandom_range(2) == 0 ? 50 : ($urandom_range(1) ? 75 : 25);
			op = ($urandom_range(99) < fill_bias) ? OP_INSERT : OP_POLL;
			case ($urandom_range(9))
				0: due = {$urandom, $urandom};
				1: due = $urandom_range(1) ? '0 : T_MAX;
				default: due = time_base + $urandom_range(24);
			endcase
			if (q_count == 0 || $urandom_range(9) == 0) begin
				now = {$urandom, $urandom};
			end else begin
				case ($urandom_range(3))
					0: now = q_due[0];
					1: now = q_due[0] - 1;
					2: now = q_due[0] + $urandom_range(30);
					default: now = time_base + $urandom_range(24);
				endcase
			end
			if ($urandom_range(15) == 0)
				time_base = time_base + $urandom_range(40);
			send_item(op, due, $urandom, $urandom, now);
		end
	endtask

	task automatic test_backpressure();
		int n;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold      = 150;
		for (n = 0; n < 40; n++)
			send_item(n % 2 ? OP_POLL : OP_INSERT, time_base + n, $urandom, $urandom,
				time_base + $urandom_range(40));
	endtask

	task automatic drain_results();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		s_tvalid     = 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_order();
		test_full_queue();
		test_random_traffic(200, 0, 0);
		test_random_traffic(190, 69, 0);
		test_random_traffic(190, 0, 69);
		test_backpressure();
		test_random_traffic(200, 9, 9);
		drain_results();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end
endmodule

// File: filelist.f
src/dom_pkg.sv
src/dom_cell.sv
src/deadline_ordered_message_queue.sv
dv/tb_deadline_ordered_message_queue.sv
